// ===== rtl/jst_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types
// for the job slot table. No dependencies.
`default_nettype none

package jst_pkg;

  localparam int SLOTS      = 256;
  localparam int SEL_RANGE  = 256;
  localparam int USED_SLOTS = (SLOTS < SEL_RANGE) ? SLOTS : SEL_RANGE;
  localparam int SLOT_W     = $clog2(USED_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int KIND_W     = 3;
  localparam int ID_W       = 31;
  localparam int SEL_W      = 8;
  localparam int FLAG_W     = 3;

  localparam logic [KIND_W-1:0] OP_ALLOC   = KIND_W'(0);
  localparam logic [KIND_W-1:0] OP_FIND    = KIND_W'(1);
  localparam logic [KIND_W-1:0] OP_RELEASE = KIND_W'(2);
  localparam logic [KIND_W-1:0] OP_ADD     = KIND_W'(3);
  localparam logic [KIND_W-1:0] OP_READ    = KIND_W'(4);

  typedef struct packed {
    logic load;
    logic rd_sel;
    logic sel_wb;
    logic alloc_step;
    logic find_step;
    logic publish;
  } jst_cmd_t;

  typedef struct packed {
    logic alloc_hit;
    logic alloc_last;
    logic find_hit;
    logic find_last;
  } jst_stat_t;

endpackage

`default_nettype wire

// ===== rtl/jst_dp.sv =====
// Datapath of the job slot table: busy bits, id and flag memories, scan
// counter, result and output registers. Depends on jst_pkg.
`default_nettype none

module jst_dp (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire jst_pkg::jst_cmd_t          cmd,
  output jst_pkg::jst_stat_t              stat,
  input  wire logic [jst_pkg::KIND_W-1:0] kind,
  input  wire logic [jst_pkg::ID_W-1:0]   proc_id,
  input  wire logic [jst_pkg::SEL_W-1:0]  slot_sel,
  input  wire logic [jst_pkg::FLAG_W-1:0] flag_bits,
  output logic      [jst_pkg::SEL_W-1:0]  slot_out,
  output logic                            ok,
  output logic      [jst_pkg::ID_W-1:0]   id_out,
  output logic      [jst_pkg::FLAG_W-1:0] flags_out
);

  // Captured word.
  logic [jst_pkg::KIND_W-1:0] op_kind;
  logic [jst_pkg::ID_W-1:0]   op_pid;
  logic [jst_pkg::SEL_W-1:0]  op_sel;
  logic [jst_pkg::FLAG_W-1:0] op_flags;

  logic [jst_pkg::USED_SLOTS-1:0] busy;
  logic [jst_pkg::ID_W-1:0]       id_mem   [jst_pkg::USED_SLOTS];
  logic [jst_pkg::FLAG_W-1:0]     flag_mem [jst_pkg::USED_SLOTS];

  logic [jst_pkg::CNT_W-1:0]  cnt;
  logic [jst_pkg::SLOT_W-1:0] cnt_idx;
  logic [jst_pkg::SLOT_W-1:0] sel_idx;
  logic                       cnt_in_range;
  logic                       sel_in_range;
  logic                       sel_busy;

  // Registered memory read stage.
  logic                       rd_vld;
  logic                       rd_busy;
  logic [jst_pkg::SLOT_W-1:0] rd_slot;
  logic [jst_pkg::ID_W-1:0]   rd_id;
  logic [jst_pkg::FLAG_W-1:0] rd_flags;
  logic [jst_pkg::SLOT_W-1:0] rd_addr;
  logic                       rd_en;

  logic [jst_pkg::SEL_W-1:0]  res_slot;
  logic                       res_ok;
  logic [jst_pkg::ID_W-1:0]   res_id;
  logic [jst_pkg::FLAG_W-1:0] res_flags;

  logic                       wr_id_en;
  logic                       wr_flag_en;
  logic [jst_pkg::SLOT_W-1:0] wr_addr;
  logic [jst_pkg::FLAG_W-1:0] wr_flags;
  logic                       sel_busy_wb;

  assign cnt_idx      = cnt[jst_pkg::SLOT_W-1:0];
  assign sel_idx      = op_sel[jst_pkg::SLOT_W-1:0];
  assign cnt_in_range = cnt < jst_pkg::CNT_W'(jst_pkg::USED_SLOTS);
  assign sel_in_range = (jst_pkg::CNT_W'(op_sel) < jst_pkg::CNT_W'(jst_pkg::USED_SLOTS));
  assign sel_busy     = sel_in_range && (op_sel != '0) && busy[sel_idx];

  assign stat.alloc_hit  = !busy[cnt_idx];
  assign stat.alloc_last = (cnt == jst_pkg::CNT_W'(jst_pkg::USED_SLOTS - 1));
  assign stat.find_hit   = rd_vld && rd_busy && (rd_id == op_pid);
  assign stat.find_last  = rd_vld && (rd_slot == jst_pkg::SLOT_W'(jst_pkg::USED_SLOTS - 1));

  assign rd_en   = cmd.rd_sel || (cmd.find_step && cnt_in_range);
  assign rd_addr = cmd.rd_sel ? sel_idx : cnt_idx;

  assign sel_busy_wb = cmd.sel_wb && rd_busy;
  assign wr_id_en    = cmd.alloc_step && stat.alloc_hit;
  assign wr_flag_en  = wr_id_en || (sel_busy_wb && (op_kind == jst_pkg::OP_ADD));
  assign wr_addr     = wr_id_en ? cnt_idx : sel_idx;
  assign wr_flags    = wr_id_en ? op_flags : (rd_flags | op_flags);

  // Memories: one write and one registered read per cycle. Free slots are
  // never read out, so the contents need no clearing.
  always_ff @(posedge clk) begin
    if (wr_id_en) begin
      id_mem[wr_addr] <= op_pid;
    end
    if (wr_flag_en) begin
      flag_mem[wr_addr] <= wr_flags;
    end
    if (rd_en) begin
      rd_id    <= id_mem[rd_addr];
      rd_flags <= flag_mem[rd_addr];
      rd_slot  <= rd_addr;
      rd_busy  <= cmd.rd_sel ? sel_busy : busy[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= '0;
      cnt    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.find_step && cnt_in_range;
      if (cmd.load) begin
        cnt <= jst_pkg::CNT_W'(1);
      end else if ((cmd.alloc_step && !stat.alloc_hit) || (cmd.find_step && cnt_in_range)) begin
        cnt <= cnt + jst_pkg::CNT_W'(1);
      end
      if (wr_id_en) begin
        busy[cnt_idx] <= 1'b1;
      end else if (sel_busy_wb && (op_kind == jst_pkg::OP_RELEASE)) begin
        busy[sel_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_kind   <= kind;
      op_pid    <= proc_id;
      op_sel    <= slot_sel;
      op_flags  <= flag_bits;
      res_slot  <= '0;
      res_ok    <= 1'b0;
      res_id    <= '0;
      res_flags <= '0;
    end else if (wr_id_en) begin
      res_slot <= jst_pkg::SEL_W'(cnt_idx);
      res_ok   <= 1'b1;
    end else if (cmd.find_step && stat.find_hit) begin
      res_slot <= jst_pkg::SEL_W'(rd_slot);
      res_ok   <= 1'b1;
    end else if (sel_busy_wb) begin
      res_slot <= op_sel;
      res_ok   <= 1'b1;
      if (op_kind == jst_pkg::OP_READ) begin
        res_id    <= rd_id;
        res_flags <= rd_flags;
      end
    end
    if (cmd.publish) begin
      slot_out  <= res_slot;
      ok        <= res_ok;
      id_out    <= res_id;
      flags_out <= res_flags;
    end
  end

  // Slot zero is reserved and must never be marked busy.
  a_slot0_free: assert property (@(posedge clk) disable iff (rst) !busy[0])
    else $error("slot zero marked busy");

  // A failed result always carries slot zero.
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (res_ok || (res_slot == '0)))
    else $error("failed result with nonzero slot");

  // An allocation that hits leaves its slot busy.
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.alloc_step && stat.alloc_hit) |=> busy[$past(cnt_idx)])
    else $error("allocated slot not busy");

endmodule

`default_nettype wire

// ===== rtl/jst_ctrl.sv =====
// Controller state machine of the job slot table: sequences one word at a
// time through the datapath and owns the output valid. Depends on jst_pkg.
`default_nettype none

module jst_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [jst_pkg::KIND_W-1:0] kind,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output jst_pkg::jst_cmd_t               cmd,
  input  wire jst_pkg::jst_stat_t         stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL_RD,
    ST_SEL_WB,
    ST_ALLOC,
    ST_FIND,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          case (kind)
            jst_pkg::OP_ALLOC:   state_next = ST_ALLOC;
            jst_pkg::OP_FIND:    state_next = ST_FIND;
            jst_pkg::OP_RELEASE: state_next = ST_SEL_RD;
            jst_pkg::OP_ADD:     state_next = ST_SEL_RD;
            jst_pkg::OP_READ:    state_next = ST_SEL_RD;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_SEL_RD: begin
        cmd.rd_sel = 1'b1;
        state_next = ST_SEL_WB;
      end
      ST_SEL_WB: begin
        cmd.sel_wb = 1'b1;
        state_next = ST_DONE;
      end
      ST_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (stat.alloc_hit || stat.alloc_last) begin
          state_next = ST_DONE;
        end
      end
      ST_FIND: begin
        cmd.find_step = 1'b1;
        if (stat.find_hit || stat.find_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // The result moves to the output register once that is free.
        cmd.publish = !out_valid || out_ready;
        if (cmd.publish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!out_valid || out_ready))
    else $error("output overwritten");

  // At most one datapath command is issued per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.rd_sel, cmd.sel_wb, cmd.alloc_step, cmd.find_step, cmd.publish}))
    else $error("conflicting datapath commands");

  // Every accepted word is followed by a result: publish leads back to idle.
  a_publish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (state == ST_IDLE) && out_valid)
    else $error("publish did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/job_slot_table.sv =====
// Job slot table top level: lowest-free-slot allocation and lookup by id.
// Steps up to the output register: release, add flags and read take a slot read, then a
// write-back; allocate scans busy bits (one busy bit per cycle); find scans ids (one memory
// read per cycle); an unused kind goes straight to the result. The next word is accepted in
// the cycle after the result is registered; a waiting result stalls only the publish step.
// Reset clears all busy bits at once; the id and flag memories need no clearing.
`default_nettype none

module job_slot_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [jst_pkg::KIND_W-1:0] kind,
  input  wire logic [jst_pkg::ID_W-1:0]   proc_id,
  input  wire logic [jst_pkg::SEL_W-1:0]  slot_sel,
  input  wire logic [jst_pkg::FLAG_W-1:0] flag_bits,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [jst_pkg::SEL_W-1:0]  slot_out,
  output logic                            ok,
  output logic      [jst_pkg::ID_W-1:0]   id_out,
  output logic      [jst_pkg::FLAG_W-1:0] flags_out
);

  jst_pkg::jst_cmd_t  cmd;
  jst_pkg::jst_stat_t stat;

  jst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  jst_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .kind      (kind),
    .proc_id   (proc_id),
    .slot_sel  (slot_sel),
    .flag_bits (flag_bits),
    .slot_out  (slot_out),
    .ok        (ok),
    .id_out    (id_out),
    .flags_out (flags_out)
  );

endmodule

`default_nettype wire

// ===== test/job_table_checker.sv =====
// Checker for the job slot table: watches both word channels, keeps its own copy of
// the slot table, predicts each answer and compares it field by field.
// Depends on jst_pkg for widths and operation codes.
`default_nettype none

module job_table_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic [jst_pkg::KIND_W-1:0] kind,
  input  wire logic [jst_pkg::ID_W-1:0]   proc_id,
  input  wire logic [jst_pkg::SEL_W-1:0]  slot_sel,
  input  wire logic [jst_pkg::FLAG_W-1:0] flag_bits,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [jst_pkg::SEL_W-1:0]  slot_out,
  input  wire logic                       ok,
  input  wire logic [jst_pkg::ID_W-1:0]   id_out,
  input  wire logic [jst_pkg::FLAG_W-1:0] flags_out,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [jst_pkg::SEL_W-1:0]  slot;
    logic                       ok;
    logic [jst_pkg::ID_W-1:0]   id;
    logic [jst_pkg::FLAG_W-1:0] flags;
  } slot_answer_t;

  logic                       slot_busy  [jst_pkg::SEL_RANGE];
  logic [jst_pkg::ID_W-1:0]   slot_id    [jst_pkg::SEL_RANGE];
  logic [jst_pkg::FLAG_W-1:0] slot_flags [jst_pkg::SEL_RANGE];
  slot_answer_t               expected_answers [$];

  // Applies one operation to the shadow table and returns the answer it gives.
  task automatic apply_job_op(input logic [jst_pkg::KIND_W-1:0] op,
                              input logic [jst_pkg::ID_W-1:0] pid,
                              input logic [jst_pkg::SEL_W-1:0] sel,
                              input logic [jst_pkg::FLAG_W-1:0] fl,
                              output slot_answer_t ans);
    int  s;
    logic sel_busy;
    ans = '0;
    sel_busy = (sel != '0) && (int'(sel) < jst_pkg::USED_SLOTS) && slot_busy[sel];
    case (op)
      jst_pkg::OP_ALLOC: begin
        for (s = 1; s < jst_pkg::USED_SLOTS && !ans.ok; s++) begin
          if (!slot_busy[s]) begin
            slot_busy[s]  = 1'b1;
            slot_id[s]    = pid;
            slot_flags[s] = fl;
            ans.slot      = jst_pkg::SEL_W'(s);
            ans.ok        = 1'b1;
          end
        end
      end
      jst_pkg::OP_FIND: begin
        for (s = 1; s < jst_pkg::USED_SLOTS && !ans.ok; s++) begin
          if (slot_busy[s] && slot_id[s] == pid) begin
            ans.slot = jst_pkg::SEL_W'(s);
            ans.ok   = 1'b1;
          end
        end
      end
      jst_pkg::OP_RELEASE: begin
        if (sel_busy) begin
          slot_busy[sel]  = 1'b0;
          slot_id[sel]    = '0;
          slot_flags[sel] = '0;
          ans.slot        = sel;
          ans.ok          = 1'b1;
        end
      end
      jst_pkg::OP_ADD: begin
        if (sel_busy) begin
          slot_flags[sel] = slot_flags[sel] | fl;
          ans.slot        = sel;
          ans.ok          = 1'b1;
        end
      end
      jst_pkg::OP_READ: begin
        if (int'(sel) < jst_pkg::USED_SLOTS) begin
          ans.id    = slot_id[sel];
          ans.flags = slot_flags[sel];
        end
        if (sel_busy) begin
          ans.slot = sel;
          ans.ok   = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  function automatic int field_bad(string fld, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t checker: %s expected %0h actual %0h", $time, fld, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    slot_answer_t want;
    int           errs;
    int           i;
    if (rst) begin
      for (i = 0; i < jst_pkg::SEL_RANGE; i++) begin
        slot_busy[i]  = 1'b0;
        slot_id[i]    = '0;
        slot_flags[i] = '0;
      end
      expected_answers.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t checker: result word with nothing expected (slot %0h ok %0b)",
                   $time, slot_out, ok);
          fail_count++;
        end else begin
          want = expected_answers.pop_front();
          errs = field_bad("slot_out", 32'(want.slot), 32'(slot_out))
               + field_bad("ok", 32'(want.ok), 32'(ok))
               + field_bad("id_out", 32'(want.id), 32'(id_out))
               + field_bad("flags_out", 32'(want.flags), 32'(flags_out));
          if (errs != 0) fail_count++;
        end
      end
      if (in_valid && in_ready) begin
        apply_job_op(kind, proc_id, slot_sel, flag_bits, want);
        expected_answers.push_back(want);
      end
    end
    pending = expected_answers.size();
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Top of the job slot table test: clock, reset, stimulus with random idling and a long
// output hold-off, watchdog and verdict. Depends on jst_pkg, job_slot_table and
// job_table_checker.
`default_nettype none

module testbench;

  localparam logic [jst_pkg::KIND_W-1:0] OP_SPARE_FIRST = jst_pkg::KIND_W'(5);
  localparam logic [jst_pkg::KIND_W-1:0] OP_SPARE_MID   = jst_pkg::KIND_W'(6);
  localparam logic [jst_pkg::KIND_W-1:0] OP_SPARE_LAST  = '1;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic [jst_pkg::KIND_W-1:0] kind;
  logic [jst_pkg::ID_W-1:0]   proc_id;
  logic [jst_pkg::SEL_W-1:0]  slot_sel;
  logic [jst_pkg::FLAG_W-1:0] flag_bits;
  logic                       out_valid;
  logic                       out_ready;
  logic [jst_pkg::SEL_W-1:0]  slot_out;
  logic                       ok;
  logic [jst_pkg::ID_W-1:0]   id_out;
  logic [jst_pkg::FLAG_W-1:0] flags_out;
  int                         fail_count;
  int                         pending;

  logic                       idle_on;
  logic                       hold_request;
  logic                       hold_done;
  int                         quiet_cycles;
  logic [jst_pkg::ID_W-1:0]   pid_pool [8];

  always #10 clk = ~clk;

  job_slot_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .proc_id(proc_id), .slot_sel(slot_sel), .flag_bits(flag_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_out(slot_out), .ok(ok), .id_out(id_out), .flags_out(flags_out)
  );

  job_table_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .proc_id(proc_id), .slot_sel(slot_sel), .flag_bits(flag_bits),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot_out(slot_out), .ok(ok), .id_out(id_out), .flags_out(flags_out),
    .fail_count(fail_count), .pending(pending)
  );

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic [jst_pkg::KIND_W-1:0] op,
                           input logic [jst_pkg::ID_W-1:0] pid,
                           input logic [jst_pkg::SEL_W-1:0] sel,
                           input logic [jst_pkg::FLAG_W-1:0] fl);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid  = 1'b1;
    kind      = op;
    proc_id   = pid;
    slot_sel  = sel;
    flag_bits = fl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic [jst_pkg::ID_W-1:0] pick_pid();
    if ($urandom_range(0, 4) != 0) return pid_pool[$urandom_range(0, 7)];
    return jst_pkg::ID_W'($urandom);
  endfunction

  // Most selectors land in the low slots where the table is populated.
  function automatic logic [jst_pkg::SEL_W-1:0] pick_sel(int hot_max);
    int r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r <= 3) return jst_pkg::SEL_W'($urandom);
    return jst_pkg::SEL_W'($urandom_range(1, hot_max));
  endfunction

  task automatic random_words(int count, int hot_max, int w_alloc, int w_find,
                              int w_release, int w_add, int w_read);
    int n;
    int r;
    logic [jst_pkg::KIND_W-1:0] op;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < w_alloc) op = jst_pkg::OP_ALLOC;
      else if (r < w_alloc + w_find) op = jst_pkg::OP_FIND;
      else if (r < w_alloc + w_find + w_release) op = jst_pkg::OP_RELEASE;
      else if (r < w_alloc + w_find + w_release + w_add) op = jst_pkg::OP_ADD;
      else if (r < w_alloc + w_find + w_release + w_add + w_read) op = jst_pkg::OP_READ;
      else op = jst_pkg::KIND_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      send_word(op, pick_pid(), pick_sel(hot_max), jst_pkg::FLAG_W'($urandom));
    end
  endtask

  // Receiver: short random stalls, plus one long hold-off that backs the block up.
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int i;
    int waited;
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = '0;
    proc_id      = '0;
    slot_sel     = '0;
    flag_bits    = '0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    pid_pool[0]  = '0;
    pid_pool[1]  = '1;
    for (i = 2; i < 8; i++) pid_pool[i] = jst_pkg::ID_W'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fresh table: reads of untouched slots, ops on free slots, an unmatched find, allocs.
    send_word(jst_pkg::OP_READ, '0, 8'd0, '0);
    send_word(jst_pkg::OP_READ, '0, 8'd1, '0);
    send_word(jst_pkg::OP_READ, '1, 8'd255, '1);
    send_word(jst_pkg::OP_RELEASE, '0, 8'd3, '0);
    send_word(jst_pkg::OP_ADD, '0, 8'd3, 3'b111);
    send_word(jst_pkg::OP_FIND, '0, 8'd0, '0);
    send_word(jst_pkg::OP_ALLOC, '1, 8'd0, 3'b111);
    send_word(jst_pkg::OP_ALLOC, '0, 8'd255, 3'b000);
    send_word(jst_pkg::OP_ALLOC, 31'h5555_5555, 8'd0, 3'b101);
    send_word(jst_pkg::OP_FIND, '1, 8'd0, '0);
    send_word(jst_pkg::OP_FIND, '0, 8'd0, '0);
    send_word(jst_pkg::OP_FIND, 31'h2AAA_AAAA, 8'd0, '0);
    send_word(jst_pkg::OP_ADD, '0, 8'd2, 3'b010);
    send_word(jst_pkg::OP_READ, '0, 8'd2, '0);
    // Slot zero is never busy.
    send_word(jst_pkg::OP_ADD, '0, 8'd0, 3'b111);
    send_word(jst_pkg::OP_RELEASE, '0, 8'd0, '0);
    send_word(jst_pkg::OP_READ, '0, 8'd0, '0);
    send_word(OP_SPARE_FIRST, '1, 8'd1, 3'b111);
    send_word(OP_SPARE_MID, '1, 8'd2, 3'b111);
    send_word(OP_SPARE_LAST, '1, 8'd255, 3'b111);
    // A released slot reads back empty and is the first one handed out again.
    send_word(jst_pkg::OP_RELEASE, '0, 8'd1, '0);
    send_word(jst_pkg::OP_READ, '0, 8'd1, '0);
    send_word(jst_pkg::OP_ALLOC, 31'h1234_5678, 8'd0, 3'b001);
    send_word(jst_pkg::OP_RELEASE, '0, 8'd2, '0);
    send_word(jst_pkg::OP_FIND, '0, 8'd0, '0);

    random_words(200, 24, 30, 20, 22, 12, 12);
    hold_request = 1'b1;
    random_words(300, 24, 30, 20, 22, 12, 12);

    // Fill the table, then work on it while it is full.
    random_words(300, 255, 100, 0, 0, 0, 0);
    random_words(40, 255, 25, 25, 15, 10, 20);

    // Drain with mostly releases; the last stretch runs without idling.
    random_words(300, 255, 15, 15, 45, 10, 12);
    idle_on = 1'b0;
    random_words(150, 255, 15, 15, 45, 10, 12);
    in_valid = 1'b0;

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending != 0) $display("%0t %0d expected words never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== job_slot_table.f =====
rtl/jst_pkg.sv
rtl/jst_dp.sv
rtl/jst_ctrl.sv
rtl/job_slot_table.sv
test/job_table_checker.sv
test/testbench.sv
